### sv/assert_macros.svh
// Assertion macros used by the checker file.
// Every check samples on the rising edge of i_clk and is masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the clock, with reset masking it.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tga checker: property failed");

// Check that one expression implies another in the same cycle.
`define ASSERT_IMPLY(label, lhs, rhs) \
    `ASSERT_CLK(label, (lhs) |-> (rhs))

`endif

### sv/tga_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; the decoder top and tga_skid import it.
`timescale 1ns / 1ps

package tga_pkg;

    localparam int unsigned MAX_RUN = 128;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_RLE_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_PIXEL_TOTAL  = 2'd2;

    // Pixel format codes
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    // Packet header fields
    localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_REPEAT  = 3'b010,
        PH_LITERAL = 3'b100
    } t_phase;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  run_length;
        logic        image_done;
        logic        status;
    } t_run;

endpackage

### sv/tga_byte_if.sv
// Input channel of the decoder: one stream byte per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface tga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

### sv/tga_run_if.sv
// Output channel of the decoder: one pixel run per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface tga_run_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        image_done;
    logic        status;

    modport source (output valid, output pixel_value, output run_length,
                    output image_done, output status, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input image_done, input status, output ready);
endinterface

### sv/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder, top level. Depends on tga_pkg, tga_byte_if,
// tga_run_if and tga_skid. A run is registered in the output register, or in
// the skid register first while the output stalls. Throughput: one byte per
// cycle while the skid stage is empty; the output register and skid stage
// let the next byte in while a run waits. i_rst_n (synchronous) loads format
// BGR, packets on, one pixel per image, and waits for a packet header.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    tga_byte_if.sink    i_in,
    tga_run_if.source   o_out
);
    import tga_pkg::*;

    // configuration
    logic [1:0]  r_pixel_format;
    logic        r_rle_enable;
    logic [31:0] r_pixel_total;

    // decoder state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_packet_left, n_packet_left;
    logic [1:0]  r_byte_slot, n_byte_slot;
    logic [7:0]  r_g0, r_g1, r_g2;
    logic [31:0] r_pixels_left, n_pixels_left;

    logic        w_accept;
    logic        w_skid_ready;
    logic [7:0]  w_b;
    logic [1:0]  w_last_slot;
    logic        w_is_header;
    logic        w_have;
    logic        w_clamp;
    logic        w_done;
    logic        w_restart;
    logic [7:0]  w_n_raw;
    logic [31:0] w_full;
    logic [31:0] w_pixel;
    logic [31:0] w_total_load;
    t_run        w_run;

    assign i_in.ready = w_skid_ready;
    assign w_accept   = i_in.valid & w_skid_ready;
    assign w_b        = i_in.data_byte;

    assign w_total_load = (r_pixel_total == 32'd0) ? 32'd1 : r_pixel_total;

    always_comb begin
        unique case (r_pixel_format)
            FMT_GRAY: w_last_slot = 2'd0;
            FMT_BGR:  w_last_slot = 2'd2;
            default:  w_last_slot = 2'd3;
        endcase
    end

    assign w_is_header = r_rle_enable & (r_phase == PH_HEADER);
    assign w_have      = !w_is_header & (r_byte_slot == w_last_slot);

    // assemble the pixel from stored bytes and the current one
    assign w_full[7:0]   = (r_byte_slot == 2'd0) ? w_b : r_g0;
    assign w_full[15:8]  = (r_byte_slot == 2'd1) ? w_b : r_g1;
    assign w_full[23:16] = (r_byte_slot == 2'd2) ? w_b : r_g2;
    assign w_full[31:24] = (r_byte_slot == 2'd3) ? w_b : 8'd0;

    // swap BGR to RGB; alpha stays on top
    assign w_pixel = (r_pixel_format == FMT_GRAY) ? {24'd0, w_full[7:0]}
                   : {w_full[31:24], w_full[7:0], w_full[15:8], w_full[23:16]};

    assign w_n_raw = (r_rle_enable && r_phase == PH_REPEAT) ? r_packet_left : 8'd1;
    assign w_clamp = ({24'd0, w_n_raw} >= r_pixels_left);
    assign w_done  = w_have & w_clamp;
    assign w_restart = w_done | i_in.stream_end;

    always_comb begin
        w_run.pixel_value = w_have ? w_pixel : 32'd0;
        w_run.run_length  = !w_have ? 8'd0 : (w_clamp ? r_pixels_left[7:0] : w_n_raw);
        w_run.image_done  = w_done;
        w_run.status      = !w_done & i_in.stream_end;
    end

    always_comb begin
        n_phase       = r_phase;
        n_packet_left = r_packet_left;
        n_byte_slot   = r_byte_slot;
        n_pixels_left = r_pixels_left;
        if (w_is_header) begin
            n_packet_left = {1'b0, w_b[6:0] & HDR_COUNT_MASK[6:0]} + 8'd1;
            n_phase       = ((w_b & HDR_REPEAT_BIT) != 8'd0) ? PH_REPEAT : PH_LITERAL;
            n_byte_slot   = 2'd0;
        end else if (w_have) begin
            n_byte_slot   = 2'd0;
            n_pixels_left = r_pixels_left - {24'd0, w_n_raw};
            if (r_rle_enable) begin
                unique case (r_phase)
                    PH_REPEAT: begin
                        n_packet_left = 8'd0;
                        n_phase       = PH_HEADER;
                    end
                    PH_LITERAL: begin
                        if (r_packet_left <= 8'd1) begin
                            n_packet_left = 8'd0;
                            n_phase       = PH_HEADER;
                        end else begin
                            n_packet_left = r_packet_left - 8'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_HEADER;
                    end
                endcase
            end
        end else begin
            n_byte_slot = r_byte_slot + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_BGR;
            r_rle_enable   <= 1'b1;
            r_pixel_total  <= 32'd1;
            r_phase        <= PH_HEADER;
            r_packet_left  <= 8'd0;
            r_byte_slot    <= 2'd0;
            r_pixels_left  <= 32'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PIXEL_FORMAT || i_cfg_index == CFG_RLE_ENABLE
                    || i_cfg_index == CFG_PIXEL_TOTAL) begin
                r_phase       <= PH_HEADER;
                r_packet_left <= 8'd0;
                r_byte_slot   <= 2'd0;
            end
            unique case (i_cfg_index)
                CFG_PIXEL_FORMAT: begin
                    r_pixel_format <= i_cfg_data[1:0];
                    r_pixels_left  <= w_total_load;
                end
                CFG_RLE_ENABLE: begin
                    r_rle_enable  <= i_cfg_data[0];
                    r_pixels_left <= w_total_load;
                end
                CFG_PIXEL_TOTAL: begin
                    r_pixel_total <= i_cfg_data;
                    r_pixels_left <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end else if (w_accept) begin
            if (w_restart) begin
                r_phase       <= PH_HEADER;
                r_packet_left <= 8'd0;
                r_byte_slot   <= 2'd0;
                r_pixels_left <= w_total_load;
            end else begin
                r_phase       <= n_phase;
                r_packet_left <= n_packet_left;
                r_byte_slot   <= n_byte_slot;
                r_pixels_left <= n_pixels_left;
            end
        end
    end

    // byte store; earlier slots are always written before they are read
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_header) begin
            unique case (r_byte_slot)
                2'd0:    r_g0 <= w_b;
                2'd1:    r_g1 <= w_b;
                2'd2:    r_g2 <= w_b;
                default: r_g2 <= r_g2;
            endcase
        end
    end

    tga_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept & (w_have | i_in.stream_end)),
        .i_run   (w_run),
        .o_ready (w_skid_ready),
        .o_out   (o_out)
    );

endmodule

### sv/tga_skid.sv
// Output register plus skid stage for decoded runs.
// Depends on tga_pkg and tga_run_if.
`timescale 1ns / 1ps

module tga_skid (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tga_pkg::t_run i_run,
    output logic         o_ready,
    tga_run_if.source    o_out
);
    import tga_pkg::*;

    logic r_main_valid, n_main_valid;
    logic r_skid_valid, n_skid_valid;
    t_run r_main, n_main;
    t_run r_skid, n_skid;
    logic w_take;

    assign w_take  = r_main_valid & o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                // drain the skid word into the output register
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_run;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_run;
            end else begin
                // hold the new word behind the stalled one
                n_skid_valid = 1'b1;
                n_skid       = i_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid       = r_main_valid;
    assign o_out.pixel_value = r_main.pixel_value;
    assign o_out.run_length  = r_main.run_length;
    assign o_out.image_done  = r_main.image_done;
    assign o_out.status      = r_main.status;

endmodule

### sv/tga_checker.sv
// Port-level checks for the TGA run-length pixel decoder, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_run_length,
    input logic        i_image_done,
    input logic        i_status
);

    // a stalled result word stays offered
    `ASSERT_CLK(a_out_hold, (i_out_valid && !i_out_ready) |=> i_out_valid)

    // the input side only stalls behind a waiting result
    `ASSERT_IMPLY(a_stall_cause, !i_in_ready, i_out_valid && $past(i_out_valid))

    // an empty run only reports a truncated stream
    `ASSERT_IMPLY(a_empty_run, i_out_valid && i_run_length == 8'd0, i_status)

    // a run never both completes the image and flags truncation
    `ASSERT_IMPLY(a_done_xor_trunc, i_out_valid, !(i_image_done && i_status))

    // runs never exceed one full packet
    `ASSERT_IMPLY(a_run_max, i_out_valid, i_run_length <= 8'd128)

endmodule

bind tga_rle_pixel_decoder tga_checker u_tga_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_run_length (o_out.run_length),
    .i_image_done (o_out.image_done),
    .i_status     (o_out.status)
);
